// File: design/mss_pkg.sv
// shared constants and control types for the max submatrix sum block
package mss_pkg;

  // default sizes
  localparam int DEF_MAX_ROWS  = 32;
  localparam int DEF_MAX_COLS  = 32;
  localparam int DEF_ELEM_BITS = 16;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_COLS = 2'd1;

  // result field widths
  localparam int SUM_OUT_W = 25;
  localparam int IDX_OUT_W = 6;

  // commands from controller to datapath
  typedef struct packed {
    logic load_we;     // write accepted element into the matrix store
    logic issue;       // start one (top, bottom, column) step of the search
    logic first_row;   // bottom row equals top row: column sums start from zero
    logic col_first;   // first column of a row pair: kadane run restarts
    logic clear_best;  // new search begins
    logic publish;     // copy best into the result register
  } mss_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pipe_busy;    // search steps still in flight
    logic out_pending;  // result register holds an untaken result
  } mss_stat_t;

endpackage

// File: design/mss_in_if.sv
// element request channel
interface mss_in_if #(
  parameter int ELEM_BITS = mss_pkg::DEF_ELEM_BITS
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// File: design/mss_out_if.sv
// result request channel
interface mss_out_if;
  import mss_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SUM_OUT_W-1:0] max_sum;
  logic [IDX_OUT_W-1:0] top_row;
  logic [IDX_OUT_W-1:0] bottom_row;
  logic [IDX_OUT_W-1:0] left_col;
  logic [IDX_OUT_W-1:0] right_col;

  modport source (output valid, output max_sum, output top_row, output bottom_row,
                  output left_col, output right_col, input ready);
  modport sink   (input valid, input max_sum, input top_row, input bottom_row,
                  input left_col, input right_col, output ready);
endinterface

// File: design/max_submatrix_sum_core.sv
// top level of the max submatrix sum block (2-d kadane search)
//
//   channel  | direction | handshake           | payload
//   in_ch    | in        | valid / ready       | element, row-major
//   out_ch   | out       | valid / ready       | max_sum, top_row, bottom_row, left_col, right_col
//   cfg_*    | in        | cfg_we, no wait     | cfg_addr 0 num_rows, 1 num_cols, cfg_wdata
//
// elements load at one per cycle while in_ready is high; the last element starts the search.
// the search visits every (top, bottom, column) step at one column step per cycle, set by the
// single read port of the element store; the pipe then drains and the result register loads.
// a result waits in its output register; the next matrix loads while it waits, and the
// following search holds its result until the register is free.
// synchronous reset; the element store needs no clearing pass.
module max_submatrix_sum_core #(
  parameter int MAX_ROWS  = mss_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = mss_pkg::DEF_MAX_COLS,
  parameter int ELEM_BITS = mss_pkg::DEF_ELEM_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mss_in_if.sink                         in_ch,
  mss_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mss_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [mss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mss_pkg::*;

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  mss_cmd_t                    cmd;
  mss_stat_t                   stat;
  logic [RIW-1:0]              ld_row;
  logic [CIW-1:0]              ld_col;
  logic [RIW-1:0]              srch_top;
  logic [RIW-1:0]              srch_bot;
  logic [CIW-1:0]              srch_col;
  logic                        in_ready;
  logic signed [ELEM_BITS-1:0] in_element;

  assign in_ch.ready = in_ready;
  assign in_element  = in_ch.element;

  // controller
  mss_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RIW      (RIW),
    .CIW      (CIW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd),
    .ld_row    (ld_row),
    .ld_col    (ld_col),
    .srch_top  (srch_top),
    .srch_bot  (srch_bot),
    .srch_col  (srch_col)
  );

  // datapath
  mss_dpath #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .ELEM_BITS (ELEM_BITS),
    .RIW       (RIW),
    .CIW       (CIW)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .ld_row         (ld_row),
    .ld_col         (ld_col),
    .srch_top       (srch_top),
    .srch_bot       (srch_bot),
    .srch_col       (srch_col),
    .in_element     (in_element),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_max_sum    (out_ch.max_sum),
    .out_top_row    (out_ch.top_row),
    .out_bottom_row (out_ch.bottom_row),
    .out_left_col   (out_ch.left_col),
    .out_right_col  (out_ch.right_col)
  );

endmodule

// File: design/mss_ctrl.sv
// controller: size registers, load counters and the row-pair / column sequencer
module mss_ctrl #(
  parameter int MAX_ROWS = mss_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mss_pkg::DEF_MAX_COLS,
  parameter int RIW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CIW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             cfg_we,
  input  logic [mss_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  mss_pkg::mss_stat_t               stat,
  output mss_pkg::mss_cmd_t                cmd,
  output logic [RIW-1:0]                   ld_row,
  output logic [CIW-1:0]                   ld_col,
  output logic [RIW-1:0]                   srch_top,
  output logic [RIW-1:0]                   srch_bot,
  output logic [CIW-1:0]                   srch_col
);
  import mss_pkg::*;

  localparam int SRW = $clog2(MAX_ROWS + 1);
  localparam int SCW = $clog2(MAX_COLS + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;

  logic [1:0]     state_r, state_nxt;
  logic [SRW-1:0] nrows_r, nrows_nxt;
  logic [SCW-1:0] ncols_r, ncols_nxt;
  logic [RIW-1:0] ld_row_r, ld_row_nxt;
  logic [CIW-1:0] ld_col_r, ld_col_nxt;
  logic [RIW-1:0] top_r, top_nxt;
  logic [RIW-1:0] bot_r, bot_nxt;
  logic [CIW-1:0] col_r, col_nxt;

  logic accept;
  logic ld_col_last, ld_row_last;
  logic col_last, bot_last, top_last;
  logic publish;

  assign in_ready = (state_r == ST_LOAD);
  assign accept   = in_valid && in_ready;

  // end-of-range flags
  assign ld_col_last = (SCW'(ld_col_r) + SCW'(1)) == ncols_r;
  assign ld_row_last = (SRW'(ld_row_r) + SRW'(1)) == nrows_r;
  assign col_last    = (SCW'(col_r) + SCW'(1)) == ncols_r;
  assign bot_last    = (SRW'(bot_r) + SRW'(1)) == nrows_r;
  assign top_last    = (SRW'(top_r) + SRW'(1)) == nrows_r;

  assign publish = (state_r == ST_DRAIN) && !stat.pipe_busy && !stat.out_pending;

  // size registers, clamped into 1..max
  always_comb begin
    nrows_nxt = nrows_r;
    ncols_nxt = ncols_r;
    if (cfg_we && cfg_addr == REG_NUM_ROWS) begin
      if (cfg_wdata == '0) begin
        nrows_nxt = SRW'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_ROWS)) begin
        nrows_nxt = SRW'(MAX_ROWS);
      end else begin
        nrows_nxt = SRW'(cfg_wdata);
      end
    end
    if (cfg_we && cfg_addr == REG_NUM_COLS) begin
      if (cfg_wdata == '0) begin
        ncols_nxt = SCW'(1);
      end else if (32'(cfg_wdata) > 32'(MAX_COLS)) begin
        ncols_nxt = SCW'(MAX_COLS);
      end else begin
        ncols_nxt = SCW'(cfg_wdata);
      end
    end
  end

  // load position, restarted by any size write
  always_comb begin
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    if (cfg_we && (cfg_addr == REG_NUM_ROWS || cfg_addr == REG_NUM_COLS)) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end else if (accept) begin
      if (ld_col_last) begin
        ld_col_nxt = '0;
        ld_row_nxt = ld_row_last ? '0 : ld_row_r + RIW'(1);
      end else begin
        ld_col_nxt = ld_col_r + CIW'(1);
      end
    end
  end

  // state and search sequencer
  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    bot_nxt   = bot_r;
    col_nxt   = col_r;
    case (state_r)
      ST_LOAD: begin
        if (accept && ld_col_last && ld_row_last) begin
          state_nxt = ST_SEARCH;
          top_nxt   = '0;
          bot_nxt   = '0;
          col_nxt   = '0;
        end
      end
      ST_SEARCH: begin
        if (col_last) begin
          col_nxt = '0;
          if (bot_last) begin
            if (top_last) begin
              state_nxt = ST_DRAIN;
            end else begin
              top_nxt = top_r + RIW'(1);
              bot_nxt = top_r + RIW'(1);
            end
          end else begin
            bot_nxt = bot_r + RIW'(1);
          end
        end else begin
          col_nxt = col_r + CIW'(1);
        end
      end
      ST_DRAIN: begin
        if (publish) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      nrows_r  <= SRW'(1);
      ncols_r  <= SCW'(1);
      ld_row_r <= '0;
      ld_col_r <= '0;
      top_r    <= '0;
      bot_r    <= '0;
      col_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      nrows_r  <= nrows_nxt;
      ncols_r  <= ncols_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      top_r    <= top_nxt;
      bot_r    <= bot_nxt;
      col_r    <= col_nxt;
    end
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.load_we    = accept;
    cmd.issue      = (state_r == ST_SEARCH);
    cmd.first_row  = (bot_r == top_r);
    cmd.col_first  = (col_r == '0);
    cmd.clear_best = accept && ld_col_last && ld_row_last;
    cmd.publish    = publish;
  end

  assign ld_row   = ld_row_r;
  assign ld_col   = ld_col_r;
  assign srch_top = top_r;
  assign srch_bot = bot_r;
  assign srch_col = col_r;

endmodule

// File: design/mss_dpath.sv
// datapath: matrix store, column sum store, kadane stage, best tracker, result register
module mss_dpath #(
  parameter int MAX_ROWS  = mss_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS  = mss_pkg::DEF_MAX_COLS,
  parameter int ELEM_BITS = mss_pkg::DEF_ELEM_BITS,
  parameter int RIW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CIW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mss_pkg::mss_cmd_t                 cmd,
  output mss_pkg::mss_stat_t                stat,
  input  logic [RIW-1:0]                    ld_row,
  input  logic [CIW-1:0]                    ld_col,
  input  logic [RIW-1:0]                    srch_top,
  input  logic [RIW-1:0]                    srch_bot,
  input  logic [CIW-1:0]                    srch_col,
  input  logic signed [ELEM_BITS-1:0]       in_element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mss_pkg::SUM_OUT_W-1:0]     out_max_sum,
  output logic [mss_pkg::IDX_OUT_W-1:0]     out_top_row,
  output logic [mss_pkg::IDX_OUT_W-1:0]     out_bottom_row,
  output logic [mss_pkg::IDX_OUT_W-1:0]     out_left_col,
  output logic [mss_pkg::IDX_OUT_W-1:0]     out_right_col
);
  import mss_pkg::*;

  localparam int SRW   = $clog2(MAX_ROWS + 1);
  localparam int SCW   = $clog2(MAX_COLS + 1);
  localparam int CS_W  = ELEM_BITS + $clog2(MAX_ROWS) + 1;
  localparam int RUN_W = CS_W + $clog2(MAX_COLS) + 1;

  // storage
  logic signed [ELEM_BITS-1:0] mat_mem [MAX_ROWS][MAX_COLS];
  logic signed [CS_W-1:0]      cs_mem  [MAX_COLS];

  // stage 1: read data and step tags
  logic signed [ELEM_BITS-1:0] mat_q_r;
  logic signed [CS_W-1:0]      cs_q_r;
  logic                        s1_valid_r;
  logic                        s1_first_r;
  logic                        s1_col0_r;
  logic                        s1_fwd_r;
  logic [RIW-1:0]              s1_top_r;
  logic [RIW-1:0]              s1_bot_r;
  logic [CIW-1:0]              s1_col_r;

  // stage 2: updated column sum feeding kadane
  logic                        s2_valid_r;
  logic                        s2_col0_r;
  logic signed [CS_W-1:0]      s2_cs_r;
  logic [RIW-1:0]              s2_top_r;
  logic [RIW-1:0]              s2_bot_r;
  logic [CIW-1:0]              s2_col_r;

  // kadane and best state
  logic signed [RUN_W-1:0]     run_r;
  logic [CIW-1:0]              run_start_r;
  logic signed [RUN_W-1:0]     best_r;
  logic [SRW-1:0]              best_top_r;
  logic [SRW-1:0]              best_bot_r;
  logic [SCW-1:0]              best_left_r;
  logic [SCW-1:0]              best_right_r;

  // result register
  logic                        out_valid_r;
  logic [SUM_OUT_W-1:0]        out_sum_r;
  logic [IDX_OUT_W-1:0]        out_top_r;
  logic [IDX_OUT_W-1:0]        out_bot_r;
  logic [IDX_OUT_W-1:0]        out_left_r;
  logic [IDX_OUT_W-1:0]        out_right_r;

  logic signed [CS_W-1:0]      cs_old;
  logic signed [CS_W-1:0]      cs_new;
  logic                        run_restart;
  logic signed [RUN_W-1:0]     run_sum;
  logic [CIW-1:0]              run_left;
  logic                        better;
  logic [RUN_W+SUM_OUT_W-1:0]  sum_ext;
  logic [SRW+IDX_OUT_W-1:0]    top_ext;
  logic [SRW+IDX_OUT_W-1:0]    bot_ext;
  logic [SCW+IDX_OUT_W-1:0]    left_ext;
  logic [SCW+IDX_OUT_W-1:0]    right_ext;

  // matrix store: written on load, read one element per search step
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mat_mem[ld_row][ld_col] <= in_element;
    end
    mat_q_r <= mat_mem[srch_bot][srch_col];
  end

  // column sum store: read at issue, written back from stage 1
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      cs_mem[s1_col_r] <= cs_new;
    end
    cs_q_r <= cs_mem[srch_col];
  end

  // stage 1 tags; forward when the same column is written back this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd.issue;
    end
    s1_first_r <= cmd.first_row;
    s1_col0_r  <= cmd.col_first;
    s1_fwd_r   <= s1_valid_r && (s1_col_r == srch_col);
    s1_top_r   <= srch_top;
    s1_bot_r   <= srch_bot;
    s1_col_r   <= srch_col;
  end

  // column sum update
  always_comb begin
    if (s1_first_r) begin
      cs_old = '0;
    end else if (s1_fwd_r) begin
      cs_old = s2_cs_r;
    end else begin
      cs_old = cs_q_r;
    end
    cs_new = cs_old + CS_W'(mat_q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_col0_r <= s1_col0_r;
    s2_cs_r   <= cs_new;
    s2_top_r  <= s1_top_r;
    s2_bot_r  <= s1_bot_r;
    s2_col_r  <= s1_col_r;
  end

  // kadane step against the running best
  always_comb begin
    run_restart = s2_col0_r || run_r[RUN_W-1] || (run_r == '0);
    run_sum     = run_restart ? RUN_W'(s2_cs_r) : run_r + RUN_W'(s2_cs_r);
    run_left    = run_restart ? s2_col_r : run_start_r;
    better      = run_sum > best_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= '0;
      run_start_r  <= '0;
      best_r       <= '0;
      best_top_r   <= '0;
      best_bot_r   <= '0;
      best_left_r  <= '0;
      best_right_r <= '0;
    end else if (cmd.clear_best) begin
      best_r       <= '0;
      best_top_r   <= '0;
      best_bot_r   <= '0;
      best_left_r  <= '0;
      best_right_r <= '0;
    end else if (s2_valid_r) begin
      run_r       <= run_sum;
      run_start_r <= run_left;
      if (better) begin
        best_r       <= run_sum;
        best_top_r   <= SRW'(s2_top_r) + SRW'(1);
        best_bot_r   <= SRW'(s2_bot_r) + SRW'(1);
        best_left_r  <= SCW'(run_left) + SCW'(1);
        best_right_r <= SCW'(s2_col_r) + SCW'(1);
      end
    end
  end

  // fit the best into the result field widths
  assign sum_ext   = {{SUM_OUT_W{1'b0}}, best_r};
  assign top_ext   = {{IDX_OUT_W{1'b0}}, best_top_r};
  assign bot_ext   = {{IDX_OUT_W{1'b0}}, best_bot_r};
  assign left_ext  = {{IDX_OUT_W{1'b0}}, best_left_r};
  assign right_ext = {{IDX_OUT_W{1'b0}}, best_right_r};

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.publish) begin
      out_sum_r   <= sum_ext[SUM_OUT_W-1:0];
      out_top_r   <= top_ext[IDX_OUT_W-1:0];
      out_bot_r   <= bot_ext[IDX_OUT_W-1:0];
      out_left_r  <= left_ext[IDX_OUT_W-1:0];
      out_right_r <= right_ext[IDX_OUT_W-1:0];
    end
  end

  assign stat.pipe_busy   = s1_valid_r || s2_valid_r;
  assign stat.out_pending = out_valid_r;

  assign out_valid      = out_valid_r;
  assign out_max_sum    = out_sum_r;
  assign out_top_row    = out_top_r;
  assign out_bottom_row = out_bot_r;
  assign out_left_col   = out_left_r;
  assign out_right_col  = out_right_r;

endmodule

// File: design/mss_checker.sv
// port-level checks for the max submatrix sum block and their bind
module mss_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mss_pkg::SUM_OUT_W-1:0]  max_sum,
  input logic [mss_pkg::IDX_OUT_W-1:0]  top_row,
  input logic [mss_pkg::IDX_OUT_W-1:0]  bottom_row,
  input logic [mss_pkg::IDX_OUT_W-1:0]  left_col,
  input logic [mss_pkg::IDX_OUT_W-1:0]  right_col
);
  import mss_pkg::*;

  // a stalled result request holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(max_sum) && $stable(top_row)
      && $stable(bottom_row) && $stable(left_col) && $stable(right_col))
    else $error("result request changed while stalled");

  // one result per matrix: a taken result is never followed at once by another
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid)
    else $error("back-to-back results");

  // a result appears when the search ends, so loading resumes with it
  a_load_resumes: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while input still blocked");

  // no positive sum gives all-zero corners
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && max_sum == '0 |->
      top_row == '0 && bottom_row == '0 && left_col == '0 && right_col == '0)
    else $error("zero sum with nonzero corners");

  // a found rectangle has ordered corners
  a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && max_sum != '0 |->
      top_row != '0 && top_row <= bottom_row && left_col != '0 && left_col <= right_col)
    else $error("rectangle corners out of order");

endmodule

bind max_submatrix_sum_core mss_checker u_mss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .max_sum    (out_ch.max_sum),
  .top_row    (out_ch.top_row),
  .bottom_row (out_ch.bottom_row),
  .left_col   (out_ch.left_col),
  .right_col  (out_ch.right_col)
);

// File: tb/mss_rect_check.sv
// rect check: watches the channels, predicts each matrix's best rectangle and compares results
module mss_rect_check
  import mss_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic signed [DEF_ELEM_BITS-1:0] in_element,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [SUM_OUT_W-1:0]        out_max_sum,
  input  logic [IDX_OUT_W-1:0]        out_top_row,
  input  logic [IDX_OUT_W-1:0]        out_bottom_row,
  input  logic [IDX_OUT_W-1:0]        out_left_col,
  input  logic [IDX_OUT_W-1:0]        out_right_col,
  output int                          mismatch_count,
  output int                          rect_due
);

  localparam int ROWS_MAX = DEF_MAX_ROWS;
  localparam int COLS_MAX = DEF_MAX_COLS;

  typedef struct packed {
    logic [SUM_OUT_W-1:0] max_sum;
    logic [IDX_OUT_W-1:0] top_row;
    logic [IDX_OUT_W-1:0] bottom_row;
    logic [IDX_OUT_W-1:0] left_col;
    logic [IDX_OUT_W-1:0] right_col;
  } rect_t;

  // local copy of the matrix, the size registers and the load position
  logic signed [DEF_ELEM_BITS-1:0] grid [ROWS_MAX][COLS_MAX];
  int unsigned n_rows;
  int unsigned n_cols;
  int unsigned fill_pos;
  rect_t       rect_due_q [$];
  int          results_seen;
  rect_t       got;
  rect_t       want;
  int unsigned cell_r;
  int unsigned cell_c;

  // zero reads as one, anything past the maximum saturates
  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // 2-d kadane over the loaded matrix, strictly greater sums replace the best
  function automatic rect_t best_rectangle();
    longint col_acc [COLS_MAX];
    longint run;
    longint row_best;
    longint best;
    int     run_first;
    int     lb_left;
    int     lb_right;
    rect_t  r;
    best = 0;
    r = '0;
    for (int t = 0; t < n_rows; t++) begin
      for (int c = 0; c < COLS_MAX; c++) col_acc[c] = 0;
      for (int b = t; b < n_rows; b++) begin
        row_best = 0;
        lb_left = 0;
        lb_right = 0;
        for (int c = 0; c < n_cols; c++) col_acc[c] += grid[b][c];
        run = 0;
        run_first = 0;
        for (int c = 0; c < n_cols; c++) begin
          if (run > 0) begin
            run += col_acc[c];
          end else begin
            run = col_acc[c];
            run_first = c;
          end
          if (run > row_best) begin
            row_best = run;
            lb_left = run_first + 1;
            lb_right = c + 1;
          end
        end
        if (row_best > best) begin
          best = row_best;
          r.top_row = IDX_OUT_W'(t + 1);
          r.bottom_row = IDX_OUT_W'(b + 1);
          r.left_col = IDX_OUT_W'(lb_left);
          r.right_col = IDX_OUT_W'(lb_right);
        end
      end
    end
    r.max_sum = best[SUM_OUT_W-1:0];
    return r;
  endfunction

  function automatic string show(rect_t r);
    return $sformatf("sum %0d rows %0d..%0d cols %0d..%0d",
                     r.max_sum, r.top_row, r.bottom_row, r.left_col, r.right_col);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      n_rows = 1;
      n_cols = 1;
      fill_pos = 0;
      rect_due_q.delete();
      mismatch_count = 0;
      results_seen = 0;
    end else begin
      // result request against the oldest prediction
      if (out_valid && out_ready) begin
        got = '{out_max_sum, out_top_row, out_bottom_row, out_left_col, out_right_col};
        results_seen++;
        if (rect_due_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d arrived with none pending: %s", results_seen, show(got));
        end else begin
          want = rect_due_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result %0d wrong: expected %s, got %s",
                       results_seen, show(want), show(got));
          end
        end
      end

      // size writes restart the load, other indexes are ignored
      if (cfg_we) begin
        case (cfg_addr)
          REG_NUM_ROWS: begin
            n_rows = clamp_dim(cfg_wdata, ROWS_MAX);
            fill_pos = 0;
          end
          REG_NUM_COLS: begin
            n_cols = clamp_dim(cfg_wdata, COLS_MAX);
            fill_pos = 0;
          end
          default: ;
        endcase
      end

      // element request: store row-major, the last one triggers a search
      if (in_valid && in_ready) begin
        if (fill_pos >= n_rows * n_cols) fill_pos = 0;
        cell_r = fill_pos / n_cols;
        cell_c = fill_pos % n_cols;
        grid[cell_r][cell_c] = in_element;
        fill_pos++;
        if (fill_pos == n_rows * n_cols) begin
          fill_pos = 0;
          rect_due_q.push_back(best_rectangle());
        end
      end
    end
    rect_due = rect_due_q.size();
  end

endmodule

// File: tb/max_submatrix_sum_core_tb.sv
// top of the max submatrix sum testbench: clock, reset, stimulus and verdict
module max_submatrix_sum_core_tb;
  import mss_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 3000;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  // element content styles
  typedef enum int {FILL_WIDE, FILL_NARROW, FILL_EDGE, FILL_SINKING} fill_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatch_count;
  int                    rect_due;
  int                    hold_req;
  bit                    tx_gaps;
  bit                    rx_gaps;
  int                    cycle_count;

  mss_in_if #(.ELEM_BITS(DEF_ELEM_BITS)) in_ch();
  mss_out_if out_ch();

  max_submatrix_sum_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  mss_rect_check rect_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_element     (in_ch.element),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_max_sum    (out_ch.max_sum),
    .out_top_row    (out_ch.top_row),
    .out_bottom_row (out_ch.bottom_row),
    .out_left_col   (out_ch.left_col),
    .out_right_col  (out_ch.right_col),
    .mismatch_count (mismatch_count),
    .rect_due       (rect_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("max_submatrix_sum_core: mismatch");
    $finish;
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        out_ch.ready = 1'b0;
        repeat (hold_req) @(negedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready = !(rx_gaps && $urandom_range(0, 99) < 7);
      end
    end
  end

  function automatic logic signed [DEF_ELEM_BITS-1:0] pick_elem(fill_t style);
    int v;
    case (style)
      FILL_WIDE:   v = int'($urandom());
      FILL_NARROW: v = int'($urandom_range(0, 40)) - 20;
      FILL_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default: begin
        if ($urandom_range(0, 7) == 0) v = int'($urandom_range(1, 1000));
        else v = -int'($urandom_range(1, 1000));
      end
    endcase
    return v[DEF_ELEM_BITS-1:0];
  endfunction

  // one element request; entered and left just after a falling edge
  task automatic push_elem(logic signed [DEF_ELEM_BITS-1:0] v);
    if (tx_gaps && $urandom_range(0, 99) < 7) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.element = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_elems(int count, fill_t style);
    repeat (count) push_elem(pick_elem(style));
  endtask

  // stop sending, wait for every pending result, then let the pipe drain
  task automatic settle();
    in_ch.valid = 1'b0;
    while (rect_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int rows;
    int cols;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.element = '0;
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_req = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset size is 1x1: every element is a whole matrix
    push_elem(-5);
    push_elem(7);
    settle();

    // 2x3 all negative gives an all-zero result; unused indexes are ignored
    write_reg(REG_NUM_ROWS, 2);
    write_reg(REG_NUM_COLS, 3);
    write_reg(REG_SPARE_2, 5);
    write_reg(REG_SPARE_3, 63);
    push_elem(-32768);
    push_elem(-1);
    push_elem(-32768);
    push_elem(-2);
    push_elem(-3);
    push_elem(-32768);
    settle();

    // partial load, then a size write restarts the matrix
    push_elem(100);
    push_elem(200);
    push_elem(300);
    settle();
    write_reg(REG_NUM_COLS, 3);
    push_elem(32767);
    push_elem(-32768);
    push_elem(32767);
    push_elem(32767);
    push_elem(-32768);
    push_elem(32767);
    settle();

    // zero row count reads as one; a tie keeps the first rectangle
    write_reg(REG_NUM_ROWS, 0);
    write_reg(REG_NUM_COLS, 4);
    push_elem(5);
    push_elem(-5);
    push_elem(5);
    push_elem(0);
    settle();

    // long result hold-off while 2x2 matrices keep coming
    write_reg(REG_NUM_ROWS, 2);
    write_reg(REG_NUM_COLS, 2);
    hold_req = HOLD_CYCLES;
    repeat (12) load_elems(4, fill_t'($urandom_range(0, 3)));
    settle();

    // tall and wide extremes through saturating writes
    write_reg(REG_NUM_ROWS, 40);
    write_reg(REG_NUM_COLS, 1);
    repeat (2) load_elems(32, fill_t'($urandom_range(0, 3)));
    settle();
    write_reg(REG_NUM_ROWS, 1);
    write_reg(REG_NUM_COLS, 63);
    repeat (2) load_elems(32, fill_t'($urandom_range(0, 3)));
    settle();

    // random small sizes, sometimes ending on a partial load
    for (int phase = 0; phase < 6; phase++) begin
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 6);
      write_reg(REG_NUM_ROWS, CFG_DATA_W'(rows));
      write_reg(REG_NUM_COLS, CFG_DATA_W'(cols));
      repeat (2) load_elems(rows * cols, fill_t'($urandom_range(0, 3)));
      if (rows * cols > 1 && $urandom_range(0, 3) == 0)
        load_elems($urandom_range(1, rows * cols - 1), FILL_WIDE);
      settle();
    end

    // all 32 rows at the largest values, no idling on either side
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_reg(REG_NUM_ROWS, 32);
    write_reg(REG_NUM_COLS, 2);
    repeat (64) push_elem(32767);
    settle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    if (mismatch_count == 0 && rect_due == 0) begin
      $display("max_submatrix_sum_core: match");
    end else begin
      $display("max_submatrix_sum_core: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/mss_pkg.sv
design/mss_in_if.sv
design/mss_out_if.sv
design/mss_ctrl.sv
design/mss_dpath.sv
design/max_submatrix_sum_core.sv
design/mss_checker.sv
tb/mss_rect_check.sv
tb/max_submatrix_sum_core_tb.sv
